[sv/u8enc_pkg.sv]
package u8enc_pkg;

   // continuation bytes after the lead byte, at most five
   localparam int MAX_CONTS   = 5;
   localparam int CONTS_WIDTH = 3;
   // payload bits that feed continuation bytes
   localparam int PAYLOAD_WIDTH = 6 * MAX_CONTS;
   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CONT_MARK = 8'h80;

   // one classified code point waiting for serialization
   typedef struct packed {
      logic [7:0]               lead_byte;
      logic [PAYLOAD_WIDTH-1:0] payload;
      logic [CONTS_WIDTH-1:0]   conts;
      logic                     invalid;
   } entry_type;

endpackage

[sv/utf8_code_point_encoder_unit.sv]
// utf8 encoder in the original six-byte form
// request channel: req_valid/req_ready with one 32-bit code point per transfer
// response channel: rsp_valid/rsp_ready with one encoded byte per transfer,
// lead byte first; rsp_last marks the final byte of a code point's sequence
// code points above 0x7fffffff give a single byte 0 with rsp_invalid and rsp_last set
// the first byte of a code point reaches the outputs through the front register, then
// the queue, then the output register
// throughput: one byte per cycle while rsp_ready is high; a code point gives one to six
// bytes (one for ascii or invalid, up to six above 0x3ffffff);
// the serializer in the back end sets the rate
// the front end registers and classifies a request and pushes it to a short queue,
// so requests keep flowing while the back end serializes an earlier code point
// reset (synchronous, active high) empties the front register, the queue and the
// output register; no clearing pass follows, the block is ready the next cycle
// when rsp_ready is low the output register holds its byte, the back end stops,
// the queue fills and req_ready drops only once front register and queue are full
module utf8_code_point_encoder_unit
   import u8enc_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_code_point,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_invalid
);

   // front to queue
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;

   // queue to back
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   // classify range, build lead byte
   u8enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_point (req_code_point),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   // decouples front from the serializer
   u8enc_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // emits lead byte then continuation bytes into the output register
   u8enc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_invalid  (rsp_invalid)
   );

endmodule

[sv/u8enc_front.sv]
module u8enc_front
   import u8enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_code_point,
   output logic        push_valid,
   input  logic        push_ready,
   output entry_type   push_entry
);

   logic      front_valid_ff, front_valid_in;
   entry_type entry_ff, entry_in;
   logic      take;

   // range classification and lead byte
   always_comb begin
      entry_in         = '0;
      entry_in.payload = req_code_point[PAYLOAD_WIDTH-1:0];
      if (req_code_point[31]) begin
         entry_in.invalid   = 1'b1;
         entry_in.conts     = CONTS_WIDTH'(0);
         entry_in.lead_byte = 8'h00;
      end else if (req_code_point <= 32'h0000_007F) begin
         entry_in.conts     = CONTS_WIDTH'(0);
         entry_in.lead_byte = req_code_point[7:0];
      end else if (req_code_point <= 32'h0000_07FF) begin
         entry_in.conts     = CONTS_WIDTH'(1);
         entry_in.lead_byte = 8'hC0 | {3'b000, req_code_point[10:6]};
      end else if (req_code_point <= 32'h0000_FFFF) begin
         entry_in.conts     = CONTS_WIDTH'(2);
         entry_in.lead_byte = 8'hE0 | {4'b0000, req_code_point[15:12]};
      end else if (req_code_point <= 32'h001F_FFFF) begin
         entry_in.conts     = CONTS_WIDTH'(3);
         entry_in.lead_byte = 8'hF0 | {5'b00000, req_code_point[20:18]};
      end else if (req_code_point <= 32'h03FF_FFFF) begin
         entry_in.conts     = CONTS_WIDTH'(4);
         entry_in.lead_byte = 8'hF8 | {6'b000000, req_code_point[25:24]};
      end else begin
         entry_in.conts     = CONTS_WIDTH'(5);
         entry_in.lead_byte = 8'hFC | {7'b0000000, req_code_point[30]};
      end
   end

   assign req_ready  = !front_valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = front_valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (take) begin
         front_valid_in = 1'b1;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= entry_in;
      end
   end

endmodule

[sv/u8enc_queue.sv]
module u8enc_queue
   import u8enc_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);

   entry_type           slot_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                push, pop;

   assign push_ready = count_ff != CntWidth'(QueueDepth);
   assign pop_valid  = count_ff != CntWidth'(0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/u8enc_back.sv]
module u8enc_back
   import u8enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  entry_type  pop_entry,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_invalid
);

   logic                     busy_ff, busy_in;
   logic [PAYLOAD_WIDTH-1:0] payload_ff, payload_in;
   logic [CONTS_WIDTH-1:0]   rem_ff, rem_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     last_ff, last_in;
   logic                     invalid_ff, invalid_in;
   logic                     out_free, emit;
   logic [5:0]               group;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = out_free && !busy_ff;
   assign emit      = out_free && (busy_ff || pop_valid);

   // next continuation group, most significant first
   always_comb begin
      case (rem_ff)
         3'd1:    group = payload_ff[5:0];
         3'd2:    group = payload_ff[11:6];
         3'd3:    group = payload_ff[17:12];
         3'd4:    group = payload_ff[23:18];
         3'd5:    group = payload_ff[29:24];
         default: group = 6'd0;
      endcase
   end

   always_comb begin
      busy_in    = busy_ff;
      payload_in = payload_ff;
      rem_in     = rem_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      invalid_in = invalid_ff;
      if (out_free && busy_ff) begin
         byte_in    = CONT_MARK | {2'b00, group};
         last_in    = rem_ff == CONTS_WIDTH'(1);
         invalid_in = 1'b0;
         rem_in     = rem_ff - 1'b1;
         busy_in    = rem_ff != CONTS_WIDTH'(1);
      end else if (out_free && pop_valid) begin
         byte_in    = pop_entry.lead_byte;
         last_in    = pop_entry.conts == CONTS_WIDTH'(0);
         invalid_in = pop_entry.invalid;
         payload_in = pop_entry.payload;
         rem_in     = pop_entry.conts;
         busy_in    = pop_entry.conts != CONTS_WIDTH'(0);
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      invalid_ff <= invalid_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_invalid  = invalid_ff;

endmodule
